/* rtl/tpu_pkg.sv */
package tpu_pkg;

  localparam int MAX_TILE_SIDE_DEF = 16;
  localparam int BLOCK_COUNT_DEF   = 1024;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_WIDTH  = 3'd0,
    REG_TILE_HEIGHT = 3'd1,
    REG_DEPTH       = 3'd2,
    REG_KIND        = 3'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DEPTH_1BPP = 2'd0,
    DEPTH_2BPP = 2'd1,
    DEPTH_4BPP = 2'd2,
    DEPTH_8BPP = 2'd3
  } depth_t;

  typedef enum logic [2:0] {
    KIND_1X1 = 3'd0,
    KIND_1X2 = 3'd1,
    KIND_2X1 = 3'd2,
    KIND_2X2 = 3'd3,
    KIND_3X3 = 3'd4,
    KIND_4X4 = 3'd5,
    KIND_4X6 = 3'd6,
    KIND_UNUSED = 3'd7
  } kind_t;

  // tiles per block, indexed by kind (unused kind acts as 1x1)
  localparam logic [4:0] KIND_AREA [8] = '{5'd1, 5'd2, 5'd2, 5'd4, 5'd9, 5'd16, 5'd24, 5'd1};

  typedef struct packed {
    logic [4:0] tile_width;
    logic [4:0] tile_height;
    depth_t     depth;
    kind_t      kind;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] last_idx;
  } q_item_t;

  typedef struct packed {
    logic [1:0] tc;
    logic [2:0] tr;
  } tile_pos_t;

  // index of the final pixel taken from one byte
  function automatic logic [2:0] pixels_last_idx(depth_t d);
    logic [2:0] r;
    case (d)
      DEPTH_1BPP: r = 3'd7;
      DEPTH_2BPP: r = 3'd3;
      DEPTH_4BPP: r = 3'd1;
      DEPTH_8BPP: r = 3'd0;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  // tile column and row of tile t within the block
  function automatic tile_pos_t place_tile(logic [4:0] t, kind_t kind);
    tile_pos_t p;
    p.tc = 2'd0;
    p.tr = 3'd0;
    case (kind)
      KIND_1X2, KIND_2X2: begin
        p.tc = t[2:1];
        p.tr = {2'b00, t[0]};
      end
      KIND_3X3: begin
        if (t >= 5'd6) begin
          p.tc = 2'd2;
          p.tr = 3'(t - 5'd6);
        end else if (t >= 5'd3) begin
          p.tc = 2'd1;
          p.tr = 3'(t - 5'd3);
        end else begin
          p.tc = 2'd0;
          p.tr = t[2:0];
        end
      end
      KIND_4X4: begin
        p.tc = t[3:2];
        p.tr = {1'b0, t[1:0]};
      end
      KIND_4X6: begin
        if (t < 5'd16) begin
          p.tc = t[3:2];
          p.tr = {1'b0, t[1:0]};
        end else begin
          // bottom rows: vertical pairs left to right
          p.tc = t[2:1];
          p.tr = 3'd4 + {2'b00, t[0]};
        end
      end
      default: begin
        p.tc = t[1:0];
        p.tr = 3'd0;
      end
    endcase
    return p;
  endfunction

endpackage

/* rtl/tpu_if.sv */
interface tpu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tpu_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic [5:0] column;
  logic [6:0] row;
  logic [9:0] block_number;
  logic       last_of_byte;
  logic       last_of_block;
  modport source (output valid, output pixel_value, output column, output row,
                  output block_number, output last_of_byte, output last_of_block,
                  input ready);
  modport sink   (input valid, input pixel_value, input column, input row,
                  input block_number, input last_of_byte, input last_of_block,
                  output ready);
endinterface

interface tpu_cfg_if;
  import tpu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/tpu_front.sv */
module tpu_front (
  input  logic             clk,
  input  logic             rst_n,
  tpu_byte_if.sink         in_bus,
  input  tpu_pkg::depth_t  depth,
  output tpu_pkg::q_item_t q_item,
  output logic             q_valid,
  input  logic             q_ready
);
  import tpu_pkg::*;

  logic    vld_r;
  q_item_t item_r;

  assign in_bus.ready = !vld_r || q_ready;
  assign q_valid      = vld_r;
  assign q_item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      vld_r <= in_bus.valid;
    end
  end

  // tag each byte with the index of its final pixel
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r.data     <= in_bus.data_byte;
      item_r.last_idx <= pixels_last_idx(depth);
    end
  end

endmodule

/* rtl/tpu_queue.sv */
module tpu_queue #(
  parameter int DEPTH = tpu_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tpu_pkg::q_item_t wr_item,
  input  logic             wr_valid,
  output logic             wr_ready,
  output tpu_pkg::q_item_t rd_item,
  output logic             rd_valid,
  input  logic             rd_ready
);
  import tpu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push, pop;

  assign wr_ready = count_r != CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

endmodule

/* rtl/tpu_back.sv */
module tpu_back #(
  parameter int MAX_TILE_SIDE = tpu_pkg::MAX_TILE_SIDE_DEF,
  parameter int BLOCK_COUNT   = tpu_pkg::BLOCK_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tpu_pkg::cfg_t    cfg,
  input  logic             pos_clear,
  input  tpu_pkg::q_item_t q_item,
  input  logic             q_valid,
  output logic             q_ready,
  tpu_pix_if.source        out_bus
);
  import tpu_pkg::*;

  localparam int SIDE_W = (MAX_TILE_SIDE > 1) ? $clog2(MAX_TILE_SIDE) : 1;
  localparam int BC_W   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

  // byte being split
  logic [7:0]        byte_r;
  logic [2:0]        last_idx_r, pix_idx_r;
  logic              have_r;
  // position counters
  logic [SIDE_W-1:0] pir_r, rit_r;
  logic [4:0]        tib_r;
  logic [BC_W-1:0]   blk_r;
  // output register
  logic              out_vld_r;
  logic [7:0]        px_r;
  logic [5:0]        col_r;
  logic [6:0]        row_r;
  logic [9:0]        bnum_r;
  logic              lbyte_r, lblk_r;

  logic [4:0]  tw, th;
  logic        advance, last_px;
  logic        pir_end, rit_end, tib_end;
  logic [7:0]  value, byte_nxt;
  logic [7:0]  col_sum, row_sum;
  logic [31:0] blk_wide;
  tile_pos_t   tp;

  function automatic logic [4:0] clamp_side(logic [4:0] v);
    logic [4:0] r;
    if (v == 5'd0) r = 5'd1;
    else if (32'(v) > MAX_TILE_SIDE) r = 5'(MAX_TILE_SIDE);
    else r = v;
    return r;
  endfunction

  assign tw      = clamp_side(cfg.tile_width);
  assign th      = clamp_side(cfg.tile_height);
  assign advance = have_r && (!out_vld_r || out_bus.ready);
  assign last_px = pix_idx_r == last_idx_r;
  assign q_ready = !have_r || (advance && last_px);

  always_comb begin
    case (cfg.depth)
      DEPTH_1BPP: begin
        value    = {7'd0, byte_r[7]};
        byte_nxt = byte_r << 1;
      end
      DEPTH_2BPP: begin
        value    = {6'd0, byte_r[7:6]};
        byte_nxt = byte_r << 2;
      end
      DEPTH_4BPP: begin
        value    = {4'd0, byte_r[7:4]};
        byte_nxt = byte_r << 4;
      end
      default: begin
        value    = byte_r;
        byte_nxt = 8'd0;
      end
    endcase
  end

  assign tp       = place_tile(tib_r, cfg.kind);
  assign col_sum  = 8'(tp.tc) * 8'(tw) + 8'(pir_r);
  assign row_sum  = 8'(tp.tr) * 8'(th) + 8'(rit_r);
  assign blk_wide = 32'(blk_r);

  assign pir_end = (7'(pir_r) + 7'd1) >= 7'(tw);
  assign rit_end = (7'(rit_r) + 7'd1) >= 7'(th);
  assign tib_end = (6'(tib_r) + 6'd1) >= 6'(KIND_AREA[cfg.kind]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r    <= 1'b0;
      out_vld_r <= 1'b0;
      pir_r     <= '0;
      rit_r     <= '0;
      tib_r     <= '0;
      blk_r     <= '0;
    end else begin
      if (q_ready && q_valid) begin
        have_r <= 1'b1;
      end else if (advance && last_px) begin
        have_r <= 1'b0;
      end

      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_vld_r <= 1'b0;
      end

      if (pos_clear) begin
        pir_r <= '0;
        rit_r <= '0;
        tib_r <= '0;
      end else if (advance) begin
        if (pir_end) begin
          pir_r <= '0;
          if (rit_end) begin
            rit_r <= '0;
            if (tib_end) begin
              tib_r <= '0;
              blk_r <= (blk_r == BC_W'(BLOCK_COUNT - 1)) ? '0 : blk_r + BC_W'(1);
            end else begin
              tib_r <= tib_r + 5'd1;
            end
          end else begin
            rit_r <= rit_r + SIDE_W'(1);
          end
        end else begin
          pir_r <= pir_r + SIDE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      byte_r     <= q_item.data;
      last_idx_r <= q_item.last_idx;
      pix_idx_r  <= 3'd0;
    end else if (advance) begin
      byte_r    <= byte_nxt;
      pix_idx_r <= pix_idx_r + 3'd1;
    end
    if (advance) begin
      px_r    <= value;
      col_r   <= col_sum[5:0];
      row_r   <= row_sum[6:0];
      bnum_r  <= blk_wide[9:0];
      lbyte_r <= last_px;
      lblk_r  <= pir_end && rit_end && tib_end;
    end
  end

  assign out_bus.valid         = out_vld_r;
  assign out_bus.pixel_value   = px_r;
  assign out_bus.column        = col_r;
  assign out_bus.row           = row_r;
  assign out_bus.block_number  = bnum_r;
  assign out_bus.last_of_byte  = lbyte_r;
  assign out_bus.last_of_block = lblk_r;

endmodule

/* rtl/tile_pixel_unpack_block_place.sv */
// packed pixel tile unpacker with block placement
// in_bus: one packed byte per item, valid/ready; out_bus: one pixel per item
// with its column and row inside the current block of tiles and the block index
// cfg_bus: register writes (tile width, tile height, depth, block kind), always
// ready; write only while the block is idle; any write to a known register
// restarts the position at the top left of a new block, the block index is kept
// a byte passes the input stage, the queue and the split stage before its first
// pixel is valid, then one pixel per cycle while out_bus.ready allows it
// a byte gives 8 >> depth pixels (2 at 4 bits per pixel); the split stage loads
// one pixel into the output register a cycle unless the output is stalled
// reset: position and block index clear to zero, registers take their defaults,
// queue empties; no clearing pass is needed
// stall: the output register holds while out_bus.ready is low; the split stage,
// the queue and the input stage keep filling and in_bus.ready drops only when
// all of them are full
module tile_pixel_unpack_block_place #(
  parameter int MAX_TILE_SIDE = tpu_pkg::MAX_TILE_SIDE_DEF,
  parameter int BLOCK_COUNT   = tpu_pkg::BLOCK_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tpu_byte_if.sink  in_bus,
  tpu_pix_if.source out_bus,
  tpu_cfg_if.sink   cfg_bus
);
  import tpu_pkg::*;

  // configuration registers
  logic [4:0] tw_r, th_r;
  depth_t     depth_r;
  kind_t      kind_r;
  cfg_t       cfg;
  logic       cfg_wr, pos_clear;

  // front to queue, queue to back
  q_item_t fr_item, q_item;
  logic    fr_valid, fr_ready_q;
  logic    q_valid, q_ready;

  assign cfg_bus.ready = 1'b1;
  assign cfg_wr        = cfg_bus.valid && cfg_bus.ready;

  // only writes to a known register restart the position
  always_comb begin
    case (reg_idx_t'(cfg_bus.index))
      REG_TILE_WIDTH, REG_TILE_HEIGHT, REG_DEPTH, REG_KIND: pos_clear = cfg_wr;
      default: pos_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r    <= 5'd8;
      th_r    <= 5'd8;
      depth_r <= DEPTH_4BPP;
      kind_r  <= KIND_1X1;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_bus.index))
        REG_TILE_WIDTH:  tw_r    <= cfg_bus.data;
        REG_TILE_HEIGHT: th_r    <= cfg_bus.data;
        REG_DEPTH:       depth_r <= depth_t'(cfg_bus.data[1:0]);
        REG_KIND:        kind_r  <= kind_t'(cfg_bus.data[2:0]);
        default: ;
      endcase
    end
  end

  assign cfg.tile_width  = tw_r;
  assign cfg.tile_height = th_r;
  assign cfg.depth       = depth_r;
  assign cfg.kind        = kind_r;

  // input stage: takes bytes and tags them with the index of their final pixel
  tpu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .depth   (depth_r),
    .q_item  (fr_item),
    .q_valid (fr_valid),
    .q_ready (fr_ready_q)
  );

  // short queue so the input side and the pixel side stall apart
  tpu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_item  (fr_item),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready_q),
    .rd_item  (q_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready)
  );

  // split stage: one pixel a cycle unless stalled, position counters, output register
  tpu_back #(
    .MAX_TILE_SIDE (MAX_TILE_SIDE),
    .BLOCK_COUNT   (BLOCK_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pos_clear (pos_clear),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .out_bus   (out_bus)
  );

`ifndef NO_ASSERTIONS
  // pixel value never exceeds the configured depth (checked at 1 and 4 bits per pixel)
  a_pix_1bpp: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && depth_r == DEPTH_1BPP |-> out_bus.pixel_value[7:1] == 7'd0)
    else $error("pixel value wider than 1 bit");

  a_pix_4bpp: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && depth_r == DEPTH_4BPP |-> out_bus.pixel_value[7:4] == 4'd0)
    else $error("pixel value wider than 4 bits");

  // at 8 bits per pixel every pixel closes its byte
  a_8bpp_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && depth_r == DEPTH_8BPP |-> out_bus.last_of_byte)
    else $error("8 bpp pixel not marked last of byte");

  // a tagged byte in the input stage waits while the queue is full
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid && !fr_ready_q |=> fr_valid)
    else $error("input stage dropped a byte");
`endif

endmodule

/* tb/tpu_pixel_scoreboard.sv */
module tpu_pixel_scoreboard (
  input  logic clk,
  input  logic rst_n,
  tpu_byte_if  byte_mon,
  tpu_pix_if   pix_mon,
  tpu_cfg_if   cfg_mon,
  output int   error_count,
  output int   pending_pixels
);
  import tpu_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic [5:0] column;
    logic [6:0] row;
    logic [9:0] block_num;
    logic       last_of_byte;
    logic       last_of_block;
  } pixel_t;

  // shadow registers
  logic [4:0] tile_w_reg;
  logic [4:0] tile_h_reg;
  depth_t     depth_reg;
  kind_t      kind_reg;

  // position inside the current block
  int         px_in_row;
  int         row_in_tile;
  int         tile_idx;
  logic [9:0] block_idx;

  pixel_t expected_pixels[$];
  pixel_t got;
  pixel_t want;
  int     fails = 0;
  int     reported = 0;

  assign error_count = fails;

  function automatic int clamp_side(logic [4:0] v);
    if (v == 5'd0) return 1;
    if (v > MAX_TILE_SIDE_DEF) return MAX_TILE_SIDE_DEF;
    return int'(v);
  endfunction

  // split one byte into pixels and place each one in the block
  task automatic unpack_byte(input logic [7:0] b);
    int bits, count, tw, th, cols, rows, tc, tr;
    pixel_t px;
    bits  = 1 << depth_reg;
    count = 8 >> depth_reg;
    tw    = clamp_side(tile_w_reg);
    th    = clamp_side(tile_h_reg);
    case (kind_reg)
      KIND_1X2: begin cols = 1; rows = 2; end
      KIND_2X1: begin cols = 2; rows = 1; end
      KIND_2X2: begin cols = 2; rows = 2; end
      KIND_3X3: begin cols = 3; rows = 3; end
      KIND_4X4: begin cols = 4; rows = 4; end
      KIND_4X6: begin cols = 4; rows = 6; end
      default:  begin cols = 1; rows = 1; end
    endcase
    for (int p = 0; p < count; p++) begin
      if (kind_reg == KIND_4X6 && tile_idx >= 16) begin
        // bottom two rows fill in vertical pairs
        tc = (tile_idx - 16) / 2;
        tr = 4 + (tile_idx - 16) % 2;
      end else if (kind_reg == KIND_4X6) begin
        tc = tile_idx / 4;
        tr = tile_idx % 4;
      end else begin
        tc = tile_idx / rows;
        tr = tile_idx % rows;
      end
      px.value         = 8'((int'(b) >> (8 - bits * (p + 1))) & ((1 << bits) - 1));
      px.column        = 6'(tc * tw + px_in_row);
      px.row           = 7'(tr * th + row_in_tile);
      px.block_num     = block_idx;
      px.last_of_byte  = (p == count - 1);
      px.last_of_block = 1'b0;
      px_in_row++;
      if (px_in_row >= tw) begin
        px_in_row = 0;
        row_in_tile++;
        if (row_in_tile >= th) begin
          row_in_tile = 0;
          tile_idx++;
          if (tile_idx >= cols * rows) begin
            tile_idx = 0;
            px.last_of_block = 1'b1;
            block_idx = (block_idx == 10'(BLOCK_COUNT_DEF - 1)) ? '0 : block_idx + 1'b1;
          end
        end
      end
      expected_pixels.insert(expected_pixels.size(), px);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tile_w_reg  = 5'd8;
      tile_h_reg  = 5'd8;
      depth_reg   = DEPTH_4BPP;
      kind_reg    = KIND_1X1;
      px_in_row   = 0;
      row_in_tile = 0;
      tile_idx    = 0;
      block_idx   = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_TILE_WIDTH:  tile_w_reg = cfg_mon.data;
          REG_TILE_HEIGHT: tile_h_reg = cfg_mon.data;
          REG_DEPTH:       depth_reg  = depth_t'(cfg_mon.data[1:0]);
          REG_KIND:        kind_reg   = kind_t'(cfg_mon.data[2:0]);
          default: ;
        endcase
        // known registers restart the position, block index kept
        if (cfg_mon.index <= REG_KIND) begin
          px_in_row   = 0;
          row_in_tile = 0;
          tile_idx    = 0;
        end
      end
      if (byte_mon.valid && byte_mon.ready)
        unpack_byte(byte_mon.data_byte);
      if (pix_mon.valid && pix_mon.ready) begin
        got.value         = pix_mon.pixel_value;
        got.column        = pix_mon.column;
        got.row           = pix_mon.row;
        got.block_num     = pix_mon.block_number;
        got.last_of_byte  = pix_mon.last_of_byte;
        got.last_of_block = pix_mon.last_of_block;
        if (expected_pixels.size() == 0) begin
          fails++;
          if (reported < 10) begin
            reported++;
            $display("unexpected pixel: value %0d col %0d row %0d block %0d lob %0b lblk %0b",
                     got.value, got.column, got.row, got.block_num,
                     got.last_of_byte, got.last_of_block);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (got.value !== want.value || got.column !== want.column ||
              got.row !== want.row || got.block_num !== want.block_num ||
              got.last_of_byte !== want.last_of_byte ||
              got.last_of_block !== want.last_of_block) begin
            fails++;
            if (reported < 10) begin
              reported++;
              $display("pixel mismatch: exp value %0d col %0d row %0d block %0d lob %0b lblk %0b",
                       want.value, want.column, want.row, want.block_num,
                       want.last_of_byte, want.last_of_block);
              $display("                got value %0d col %0d row %0d block %0d lob %0b lblk %0b",
                       got.value, got.column, got.row, got.block_num,
                       got.last_of_byte, got.last_of_block);
            end
          end
        end
      end
    end
    pending_pixels <= expected_pixels.size();
  end

endmodule

/* tb/tb_tile_pixel_unpack_block_place.sv */
module tb_tile_pixel_unpack_block_place;
  import tpu_pkg::*;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum {RX_OPEN, RX_CHOPPY, RX_THROTTLE} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;

  // results from the scoreboard
  int errors;
  int pending;

  // sender pacing
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // bumped by the stimulus to ask the receiver for one long hold-off
  int hold_requests = 0;

  tpu_byte_if byte_bus ();
  tpu_pix_if  pix_bus ();
  tpu_cfg_if  cfg_bus ();

  tile_pixel_unpack_block_place uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (byte_bus),
    .out_bus (pix_bus),
    .cfg_bus (cfg_bus)
  );

  tpu_pixel_scoreboard pixel_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_mon       (byte_bus),
    .pix_mon        (pix_bus),
    .cfg_mon        (cfg_bus),
    .error_count    (errors),
    .pending_pixels (pending)
  );

  always #2 clk = ~clk;

  // offer one byte, in bursts with random gaps between them while gaps_on is set
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        byte_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    do @(posedge clk); while (!byte_bus.ready);
  endtask

  // stop sending and wait for every predicted pixel to come out
  task automatic wait_idle();
    byte_bus.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // leaves cfg valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // write all four registers once the block has drained
  task automatic configure(input logic [4:0] w, input logic [4:0] h,
                           input depth_t d, input kind_t k);
    wait_idle();
    write_reg(REG_TILE_WIDTH, w);
    write_reg(REG_TILE_HEIGHT, h);
    write_reg(REG_DEPTH, 5'(d));
    write_reg(REG_KIND, 5'(k));
    cfg_bus.valid <= 1'b0;
  endtask

  // receiver: stalls on a pattern of its own, plus long hold-offs on request
  initial begin
    rx_mode_t mode;
    int mode_left;
    int stall_left;
    int served;
    int tick;
    mode       = RX_OPEN;
    mode_left  = 0;
    stall_left = 0;
    served     = 0;
    tick       = 0;
    pix_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (served != hold_requests) begin
        served     = hold_requests;
        stall_left = 64;
      end
      if (stall_left > 0) begin
        // long hold-off so the queue fills and input ready drops
        stall_left--;
        pix_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(8, 48);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   pix_bus.ready <= 1'b1;
          RX_CHOPPY: pix_bus.ready <= ($urandom_range(0, 3) != 0);
          default:   pix_bus.ready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [4:0] w;
    logic [4:0] h;
    int n;
    rst_n              <= 1'b0;
    byte_bus.valid     <= 1'b0;
    byte_bus.data_byte <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= '0;
    cfg_bus.data       <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: 8x8 tiles, 4 bits per pixel, single tile block
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hA5);
    push_byte(8'h5A);

    // zero width acts as 1, oversized height acts as 16
    configure(5'd0, 5'd31, DEPTH_1BPP, KIND_4X6);
    push_byte(8'h80);
    push_byte(8'h01);
    push_byte(8'h7E);

    // one pixel tiles: a whole 4x6 block including the paired bottom rows
    configure(5'd1, 5'd1, DEPTH_1BPP, KIND_4X6);
    push_byte(8'hC3);
    push_byte(8'h3C);
    push_byte(8'hFF);

    // unused block kind behaves as single tile, width 17 clamps to 16
    configure(5'd17, 5'd2, DEPTH_2BPP, KIND_UNUSED);
    push_byte(8'hE4);
    push_byte(8'h1B);

    // writes to unmapped indexes must not restart the position
    wait_idle();
    write_reg(REG_SPARE_LO, 5'd31);
    write_reg(REG_SPARE_HI, 5'd0);
    cfg_bus.valid <= 1'b0;
    push_byte(8'h6C);
    push_byte(8'h93);

    // full 3x3 block of 2x1 tiles
    configure(5'd2, 5'd1, DEPTH_1BPP, KIND_3X3);
    push_byte(8'h55);
    push_byte(8'hAA);
    push_byte(8'h99);

    // 8 bits per pixel, one pixel per byte, block ends on every other byte
    configure(5'd1, 5'd1, DEPTH_8BPP, KIND_2X1);
    push_byte(8'h01);
    push_byte(8'hFE);
    push_byte(8'h7F);
    push_byte(8'h80);

    // far column: 16 wide single row tiles out to the last tile column,
    // with a long receiver hold-off while the sender keeps offering
    configure(5'd16, 5'd1, DEPTH_1BPP, KIND_4X6);
    gaps_on = 1'b0;
    hold_requests++;
    repeat (26) push_byte(8'($urandom_range(0, 255)));
    gaps_on = 1'b1;

    // far row: single column tiles 16 tall down into the paired bottom rows
    configure(5'd1, 5'd16, DEPTH_1BPP, KIND_4X6);
    repeat (36) push_byte(8'($urandom_range(0, 255)));

    // random phases, one per block kind, mostly small tiles
    for (int ph = 0; ph < 8; ph++) begin
      w = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4));
      h = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4));
      configure(w, h, depth_t'($urandom_range(0, 3)), kind_t'(ph));
      gaps_on = (ph % 3 != 0);
      n = $urandom_range(2, 5);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0:       push_byte(8'h00);
          1:       push_byte(8'hFF);
          default: push_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[tile_pixel_unpack_block_place] OK");
    end else begin
      $display("[tile_pixel_unpack_block_place] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(4 * 100000);
    $display("[tile_pixel_unpack_block_place] ERROR");
    $finish;
  end

endmodule
